[rtl/core/ttc_pkg.sv]
// shared types and constants for the text console cursor controller
`default_nettype none

package ttc_pkg;

  // operation codes carried in the func field
  typedef enum logic [2:0] {
    FUNC_PUTC    = 3'd0,
    FUNC_GOTO    = 3'd1,
    FUNC_HOME    = 3'd2,
    FUNC_CLEAR   = 3'd3,
    FUNC_SAVE    = 3'd4,
    FUNC_RESTORE = 3'd5
  } ttc_func_t;

  // configuration register indexes
  localparam logic REG_LAST_COLUMN = 1'b0;
  localparam logic REG_LAST_ROW    = 1'b1;

  localparam logic [7:0] LAST_COLUMN_RESET = 8'd39;
  localparam logic [7:0] LAST_ROW_RESET    = 8'd31;

  // control characters and printable range
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_DEL      = 8'h7F;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_code;
    logic [7:0] target_row;
    logic [7:0] target_column;
  } ttc_in_t;

  typedef struct packed {
    logic       glyph_write;
    logic [7:0] glyph_column;
    logic [7:0] glyph_row;
    logic [6:0] glyph_code;
    logic       scroll_up;
    logic       clear_screen;
    logic [7:0] cursor_column;
    logic [7:0] cursor_row;
  } ttc_out_t;

  // one cursor position
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
  } ttc_pos_t;

endpackage

`default_nettype wire

[rtl/core/ttc_step.sv]
// combinational cursor update for one operation
`default_nettype none

module ttc_step #(
  parameter int TAB_WIDTH = 4
) (
  input  ttc_pkg::ttc_in_t  item,
  input  ttc_pkg::ttc_pos_t cursor,
  input  ttc_pkg::ttc_pos_t saved,
  input  logic [7:0]        last_col,
  input  logic [7:0]        last_row,
  output ttc_pkg::ttc_out_t result,
  output ttc_pkg::ttc_pos_t cursor_next,
  output ttc_pkg::ttc_pos_t saved_next
);
  import ttc_pkg::*;

  typedef logic [8:0] stop_tbl_t [256];

  // next tab stop for every column, built at elaboration
  function automatic stop_tbl_t build_stops();
    stop_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 9'((i / TAB_WIDTH + 1) * TAB_WIDTH);
    end
    return t;
  endfunction

  localparam stop_tbl_t TAB_STOP = build_stops();

  logic [7:0] cc;
  logic [7:0] cr;
  logic [8:0] col9;
  logic [8:0] row9;
  logic [7:0] goto_col;
  logic [7:0] goto_row;
  logic [7:0] rest_col;
  logic [7:0] rest_row;
  logic       printable;

  // clamp to the current limits first
  assign cc = (cursor.col > last_col) ? last_col : cursor.col;
  assign cr = (cursor.row > last_row) ? last_row : cursor.row;

  assign printable = (item.char_code >= CH_PRINT_LO) && (item.char_code < CH_DEL);

  always_comb begin
    goto_col = (item.target_column == 8'd0) ? 8'd0 : item.target_column - 8'd1;
    goto_row = (item.target_row == 8'd0) ? 8'd0 : item.target_row - 8'd1;
    if (goto_col > last_col) goto_col = last_col;
    if (goto_row > last_row) goto_row = last_row;
    rest_col = (saved.col > last_col) ? last_col : saved.col;
    rest_row = (saved.row > last_row) ? last_row : saved.row;
  end

  always_comb begin
    result      = '0;
    saved_next  = saved;
    col9        = {1'b0, cc};
    row9        = {1'b0, cr};
    unique case (item.func)
      FUNC_PUTC: begin
        if (item.char_code == CH_CR) begin
          col9 = '0;
        end else if (item.char_code == CH_LF) begin
          row9 = row9 + 9'd1;
          col9 = '0;
        end else if (item.char_code == CH_BS) begin
          if (cc != 8'd0) col9 = col9 - 9'd1;
        end else if (item.char_code == CH_TAB) begin
          col9 = TAB_STOP[cc];
        end else if (printable) begin
          result.glyph_write  = 1'b1;
          result.glyph_column = cc;
          result.glyph_row    = cr;
          result.glyph_code   = item.char_code[6:0];
          col9 = col9 + 9'd1;
        end
        // wrap past the last column, then scroll past the last row
        if (col9 > {1'b0, last_col}) begin
          col9 = '0;
          row9 = row9 + 9'd1;
        end
        if (row9 > {1'b0, last_row}) begin
          result.scroll_up = 1'b1;
          row9 = {1'b0, last_row};
        end
      end
      FUNC_GOTO: begin
        col9 = {1'b0, goto_col};
        row9 = {1'b0, goto_row};
      end
      FUNC_HOME: begin
        col9 = '0;
        row9 = '0;
      end
      FUNC_CLEAR: begin
        result.clear_screen = 1'b1;
        col9 = '0;
        row9 = '0;
      end
      FUNC_SAVE: begin
        saved_next.col = cc;
        saved_next.row = cr;
      end
      FUNC_RESTORE: begin
        col9 = {1'b0, rest_col};
        row9 = {1'b0, rest_row};
      end
      default: begin
      end
    endcase
    cursor_next.col      = col9[7:0];
    cursor_next.row      = row9[7:0];
    result.cursor_column = col9[7:0];
    result.cursor_row    = row9[7:0];
  end

endmodule

`default_nettype wire

[rtl/core/text_console_cursor_control_top.sv]
// top level of the text console cursor controller
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in      | in        | in_valid/in_stall  | in_data (ttc_in_t)
//  out     | out       | out_valid/out_stall| out_data (ttc_out_t)
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// one operation per cycle sustained while out_stall is low; an accepted operation
// passes through the input register, then the result register, which raises out_valid
// cursor state updates in the cycle the operation moves into the result register
// rst clears cursor, saved cursor, both valids and restores last_column 39, last_row 31
// a stalled result holds; the input register keeps taking items until it is full
// behind the stalled result
`default_nettype none

module text_console_cursor_control_top #(
  parameter int TAB_WIDTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ttc_pkg::ttc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ttc_pkg::ttc_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);
  import ttc_pkg::*;

  // input register
  logic     s1_valid;
  ttc_in_t  s1_item;

  // architectural state
  ttc_pos_t cursor;
  ttc_pos_t saved;
  logic [7:0] last_col;
  logic [7:0] last_row;

  ttc_out_t result;
  ttc_pos_t cursor_next;
  ttc_pos_t saved_next;

  logic take_in;
  logic advance;

  // the input register moves on when the result register is empty or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_item <= in_data;
    end
  end

  ttc_step #(
    .TAB_WIDTH(TAB_WIDTH)
  ) u_step (
    .item       (s1_item),
    .cursor     (cursor),
    .saved      (saved),
    .last_col   (last_col),
    .last_row   (last_row),
    .result     (result),
    .cursor_next(cursor_next),
    .saved_next (saved_next)
  );

  // cursor state commits with the result transfer into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      saved  <= '0;
    end else if (advance) begin
      cursor <= cursor_next;
      saved  <= saved_next;
    end
  end

  // configuration writes, to be issued only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= LAST_COLUMN_RESET;
      last_row <= LAST_ROW_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_LAST_COLUMN) last_col <= cfg_data;
      if (cfg_index == REG_LAST_ROW)    last_row <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ttc_checker.sv]
// port-level checks for the text console cursor controller, with bind
`default_nettype none

module ttc_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input ttc_pkg::ttc_out_t out_data
);
  import ttc_pkg::*;

  // a result waiting on a stalled receiver stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // no glyph means zeroed glyph fields
  a_glyph_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.glyph_write |->
      out_data.glyph_column == 8'd0 && out_data.glyph_row == 8'd0 &&
      out_data.glyph_code == 7'd0)
    else $error("glyph fields set without a glyph write");

  // a drawn glyph is printable
  a_glyph_print: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.glyph_write |->
      out_data.glyph_code >= CH_PRINT_LO[6:0] && out_data.glyph_code != CH_DEL[6:0])
    else $error("glyph code not printable");

  // clear homes the cursor and does nothing else
  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clear_screen |->
      out_data.cursor_column == 8'd0 && out_data.cursor_row == 8'd0 &&
      !out_data.glyph_write && !out_data.scroll_up)
    else $error("clear without cursor home");

endmodule

bind text_console_cursor_control_top ttc_checker u_ttc_checker (.*);

`default_nettype wire
